// ===== rtl/core/cmap_pkg.sv =====
// Shared types and constants for the RGB colormap scaler core.
// No dependencies; imported by cmap_scale and the top level.
package cmap_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int LAST_W   = 12;   // table_last and quotient width
    localparam int IDX_W    = 17;   // wide enough to hold any table depth
    localparam int NUM_W    = 46;   // 2*num*last + den
    localparam int DEN_W    = 33;   // 2*den
    localparam int PROD_W   = 44;   // num * last
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;

    // Register stages inside one scaling lane, input word to table address
    localparam int SCALE_LAT = 16;

    // Command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    // Pixel kinds
    localparam logic [1:0] KIND_BG   = 2'd0;
    localparam logic [1:0] KIND_NAN  = 2'd1;
    localparam logic [1:0] KIND_GOOD = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GREEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BLUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BLUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LAST = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILL       = 3'd7;

    // How a lane picks its table entry
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_LAST,
        MODE_DIV
    } mode_t;

    // Sideband traveling next to the lanes
    typedef struct packed {
        logic        valid;
        logic        cmd;
        logic [2:0]  fin;
        logic [2:0]  ins;
        logic [1:0]  tab_ch;
        logic [11:0] tab_idx;
        logic [7:0]  tab_byte;
    } side_t;

    // Sideband at the table read stage
    typedef struct packed {
        logic       valid;
        logic       cmd;
        logic [2:0] fin;
        logic [2:0] ins;
    } mem_side_t;

endpackage

// ===== rtl/core/cmap_scale.sv =====
// One channel lane: window compare, multiply and a 12-stage restoring divider
// that turn a sample into a capped table address. Depends on cmap_pkg.
module cmap_scale
    import cmap_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [SAMPLE_W-1:0] win_low,
    input  logic signed [SAMPLE_W-1:0] win_high,
    input  logic [LAST_W-1:0]          table_last,
    output logic [AW-1:0]              addr
);

    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_DEPTH - 1);

    // Stage 1: offsets and window decision
    logic [SAMPLE_W-1:0] num_reg, num_next;
    logic [SAMPLE_W-1:0] den_reg, den_next;
    mode_t               mode1_reg, mode1_next;
    logic [SAMPLE_W:0]   diff_v, diff_w;

    always_comb begin
        diff_v = {sample[SAMPLE_W-1], sample} - {win_low[SAMPLE_W-1], win_low};
        diff_w = {win_high[SAMPLE_W-1], win_high} - {win_low[SAMPLE_W-1], win_low};
        num_next = diff_v[SAMPLE_W-1:0];
        den_next = diff_w[SAMPLE_W-1:0];
        if (sample <= win_low) begin
            mode1_next = MODE_ZERO;
        end else if (sample >= win_high) begin
            mode1_next = MODE_LAST;
        end else begin
            mode1_next = MODE_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg   <= num_next;
            den_reg   <= den_next;
            mode1_reg <= mode1_next;
        end
    end

    // Stage 2: num * last
    logic [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0] den2_reg;
    mode_t               mode2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= PROD_W'(num_reg) * PROD_W'(table_last);
            den2_reg  <= den_reg;
            mode2_reg <= mode1_reg;
        end
    end

    // Stage 3 and divider stages: rem[0] is the dividend
    logic [NUM_W-1:0]  rem_reg  [0:LAST_W];
    logic [DEN_W-1:0]  dvs_reg  [0:LAST_W];
    logic [LAST_W-1:0] quo_reg  [0:LAST_W];
    mode_t             mode_reg [0:LAST_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {prod_reg, 1'b0} + NUM_W'(den2_reg);
            dvs_reg[0]  <= {den2_reg, 1'b0};
            quo_reg[0]  <= '0;
            mode_reg[0] <= mode2_reg;
        end
    end

    // One quotient bit per stage, most significant first
    genvar j;
    generate
        for (j = 1; j <= LAST_W; j++) begin : g_div
            localparam int SH = LAST_W - j;
            logic [NUM_W:0] trial;

            assign trial = {1'b0, rem_reg[j-1]} - ((NUM_W + 1)'(dvs_reg[j-1]) << SH);

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j]  <= trial[NUM_W] ? rem_reg[j-1] : trial[NUM_W-1:0];
                    quo_reg[j]  <= quo_reg[j-1] | (LAST_W'(!trial[NUM_W]) << SH);
                    dvs_reg[j]  <= dvs_reg[j-1];
                    mode_reg[j] <= mode_reg[j-1];
                end
            end
        end
    endgenerate

    // Final stage: pick entry and cap at the table's end
    logic [IDX_W-1:0] idx;
    logic [AW-1:0]    addr_reg;

    always_comb begin
        case (mode_reg[LAST_W])
            MODE_ZERO: idx = '0;
            MODE_LAST: idx = IDX_W'(table_last);
            default:   idx = IDX_W'(quo_reg[LAST_W]);
        endcase
        if (idx > LAST_ENTRY) begin
            idx = LAST_ENTRY;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            addr_reg <= idx[AW-1:0];
        end
    end

    assign addr = addr_reg;

endmodule

// ===== rtl/core/cmap_table.sv =====
// Single-port colour table of one channel with registered read data.
// Depends on cmap_pkg for nothing beyond convention; standalone memory.
module cmap_table #(
    parameter int TABLE_DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          wr_en,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wr_byte,
    output logic [7:0]    rd_byte
);

    logic [7:0] mem [0:TABLE_DEPTH-1];
    logic [7:0] rd_reg;

    // Write or read one entry per advancing cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_en) begin
                mem[addr] <= wr_byte;
            end
            rd_reg <= mem[addr];
        end
    end

    assign rd_byte = rd_reg;

endmodule

// ===== rtl/core/rgb_pixel_colormap_scaler_core.sv =====
// Top level of the RGB colormap scaler: config registers, three lanes,
// three colour tables and output stage. Depends on cmap_pkg, cmap_scale, cmap_table.
//
// Usage:
//  - s_ channel takes one word per cycle while s_tready is high. s_tuser = 0: pixel with three samples
//    and finite/inside masks; s_tuser = 1: one colour table byte write.
//  - m_ channel gives one word per pixel (none for table writes): RGB in tdata,
//    pixel kind in tuser (0 background, 1 nan, 2 good).
//  - Throughput is one word per cycle while m_tready does not stall the output,
//    set by the fully pipelined lanes (subtract, multiply, one divider stage
//    per quotient bit, table read, output register).
//  - Table writes pass the same pipeline and land in order with pixel reads.
//  - The config port writes a register whenever cfg_wr_en is high; write only
//    while the pipeline is empty.
//  - Reset clears all valid bits and loads the register defaults; table
//    contents are undefined until written and need no clearing.
//  - When m_tready is low with a word waiting, the whole pipeline holds and
//    s_tready drops; nothing is lost or repeated.
module rgb_pixel_colormap_scaler_core
    import cmap_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: sample_red, sample_green, sample_blue, finite_mask, inside_mask,
    //        table_channel, table_index, table_byte, zero pad
    input  logic [127:0]         s_tdata,
    // tuser: cmd
    input  logic [0:0]           s_tuser,
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: red, green, blue
    output logic [23:0]          m_tdata,
    // tuser: pixel_kind
    output logic [1:0]           m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_DEPTH - 1);

    logic advance;
    logic m_tvalid_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Config registers
    logic [SAMPLE_W-1:0] win_low_reg  [0:2];
    logic [SAMPLE_W-1:0] win_high_reg [0:2];
    logic [LAST_W-1:0]   last_reg;
    logic [CFG_W-1:0]    fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                win_low_reg[k]  <= '0;
                win_high_reg[k] <= SAMPLE_W'(255);
            end
            last_reg <= LAST_W'(255);
            fill_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LOW_RED:    win_low_reg[0]  <= cfg_data[SAMPLE_W-1:0];
                REG_HIGH_RED:   win_high_reg[0] <= cfg_data[SAMPLE_W-1:0];
                REG_LOW_GREEN:  win_low_reg[1]  <= cfg_data[SAMPLE_W-1:0];
                REG_HIGH_GREEN: win_high_reg[1] <= cfg_data[SAMPLE_W-1:0];
                REG_LOW_BLUE:   win_low_reg[2]  <= cfg_data[SAMPLE_W-1:0];
                REG_HIGH_BLUE:  win_high_reg[2] <= cfg_data[SAMPLE_W-1:0];
                REG_TABLE_LAST: last_reg        <= cfg_data[LAST_W-1:0];
                REG_FILL:       fill_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sideband shift line, aligned with the lane stages
    side_t side_reg [0:SCALE_LAT-1];
    side_t side_next;

    always_comb begin
        side_next.valid    = s_tvalid;
        side_next.cmd      = s_tuser[0];
        side_next.fin      = s_tdata[98:96];
        side_next.ins      = s_tdata[101:99];
        side_next.tab_ch   = s_tdata[103:102];
        side_next.tab_idx  = s_tdata[115:104];
        side_next.tab_byte = s_tdata[123:116];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SCALE_LAT; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (advance) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < SCALE_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Lanes and tables
    side_t            tail;
    logic [IDX_W-1:0] tab_idx_w;
    logic             tab_in_range;
    logic [7:0]       rd_byte [0:2];

    assign tail         = side_reg[SCALE_LAT-1];
    assign tab_idx_w    = IDX_W'(tail.tab_idx);
    assign tab_in_range = tab_idx_w <= LAST_ENTRY;

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_ch
            logic [AW-1:0] lane_addr;
            logic [AW-1:0] mem_addr;
            logic          wr_ok;

            cmap_scale #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .AW          (AW)
            ) u_scale (
                .aclk       (aclk),
                .en         (advance),
                .sample     (s_tdata[SAMPLE_W*k +: SAMPLE_W]),
                .win_low    (win_low_reg[k]),
                .win_high   (win_high_reg[k]),
                .table_last (last_reg),
                .addr       (lane_addr)
            );

            assign wr_ok = tail.valid && (tail.cmd == CMD_TABLE)
                           && (tail.tab_ch == 2'(k)) && tab_in_range;
            assign mem_addr = (tail.cmd == CMD_TABLE) ? tab_idx_w[AW-1:0] : lane_addr;

            cmap_table #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .AW          (AW)
            ) u_table (
                .aclk    (aclk),
                .en      (advance),
                .wr_en   (wr_ok),
                .addr    (mem_addr),
                .wr_byte (tail.tab_byte),
                .rd_byte (rd_byte[k])
            );
        end
    endgenerate

    // Table read stage sideband
    mem_side_t mem_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_side_reg.valid <= 1'b0;
        end else if (advance) begin
            mem_side_reg.valid <= tail.valid;
            mem_side_reg.cmd   <= tail.cmd;
            mem_side_reg.fin   <= tail.fin;
            mem_side_reg.ins   <= tail.ins;
        end
    end

    // Output stage: classify pixel and apply fill colours
    logic [2:0]  ch_ok;
    logic        good;
    logic        nan;
    logic [23:0] fill_rgb;
    logic [23:0] data_next;
    logic [1:0]  kind_next;
    logic [23:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    always_comb begin
        ch_ok    = mem_side_reg.ins & mem_side_reg.fin;
        good     = |ch_ok;
        nan      = |(mem_side_reg.ins & ~mem_side_reg.fin);
        fill_rgb = nan ? fill_reg[23:0] : fill_reg[47:24];
        if (good) begin
            kind_next = KIND_GOOD;
            data_next = {ch_ok[2] ? rd_byte[2] : 8'd0,
                         ch_ok[1] ? rd_byte[1] : 8'd0,
                         ch_ok[0] ? rd_byte[0] : 8'd0};
        end else begin
            kind_next = nan ? KIND_NAN : KIND_BG;
            data_next = {fill_rgb[7:0], fill_rgb[15:8], fill_rgb[23:16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= mem_side_reg.valid && (mem_side_reg.cmd == CMD_PIXEL);
            m_tdata_reg  <= data_next;
            m_tuser_reg  <= kind_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // a table write reaching the output stage gives no word
    a_write_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mem_side_reg.valid && mem_side_reg.cmd == CMD_TABLE) |=> !m_tvalid)
        else $error("table write produced an output word");

    // a held output word stalls the input side
    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // pipeline empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !mem_side_reg.valid))
        else $error("valid word after reset");

    // every valid output word carries a known pixel kind code
    a_kind_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_BG || m_tuser == KIND_NAN || m_tuser == KIND_GOOD))
        else $error("unknown pixel kind");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for rgb_pixel_colormap_scaler_core.
// Depends on cmap_pkg and the core; drives pixel and table words, checks RGB out.
module testbench;
    import cmap_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int PIPE_LAT  = 18;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 490;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [127:0]         s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic [1:0]           m_tuser;

    typedef struct {
        logic            cmd;
        logic [31:0]     smp [3];
        logic [2:0]      fin;
        logic [2:0]      ins;
        logic [1:0]      tch;
        logic [11:0]     tidx;
        logic [7:0]      tbyte;
    } word_t;

    typedef struct {
        logic [23:0] rgb;
        logic [1:0]  kind;
    } pix_t;

    // Directed rows: known result only where obvious
    typedef struct {
        word_t w;
        bit    known;
        pix_t  res;
    } row_t;

    // Predictor state
    logic signed [31:0] win_lo [3];
    logic signed [31:0] win_hi [3];
    logic [11:0]        tab_last;
    logic [47:0]        fill;
    logic [7:0]         lut [3][DEPTH];
    bit                 written [3][DEPTH];

    pix_t pending_pix[$];
    int   fails = 0;
    int   idle_cycles = 0;

    rgb_pixel_colormap_scaler_core #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Window scaling to a table entry
    function automatic logic [11:0] lut_entry(int k, logic signed [31:0] v);
        longint lo, hi, num, den, ix;
        lo = win_lo[k];
        hi = win_hi[k];
        if (v <= lo) ix = 0;
        else if (v >= hi) ix = longint'(tab_last);
        else begin
            num = longint'(v) - lo;
            den = hi - lo;
            ix = (2 * num * longint'(tab_last) + den) / (2 * den);
        end
        if (ix > DEPTH - 1) ix = DEPTH - 1;
        return ix[11:0];
    endfunction

    function automatic void predict_pixel(word_t w);
        pix_t p;
        logic [7:0]  ch [3];
        logic [23:0] c;
        bit good, nan;
        good = 0; nan = 0;
        for (int k = 0; k < 3; k++) begin
            ch[k] = 8'd0;
            if (w.ins[k]) begin
                if (w.fin[k]) begin
                    ch[k] = lut[k][lut_entry(k, w.smp[k])];
                    good = 1;
                end else nan = 1;
            end
        end
        if (good) begin
            p.kind = KIND_GOOD;
            p.rgb = {ch[2], ch[1], ch[0]};
        end else begin
            c = nan ? fill[23:0] : fill[47:24];
            p.kind = nan ? KIND_NAN : KIND_BG;
            p.rgb = {c[7:0], c[15:8], c[23:16]};
        end
        pending_pix.push_back(p);
    endfunction

    function automatic void predict_word(word_t w);
        if (w.cmd == CMD_TABLE) begin
            if (w.tch < 3 && w.tidx < DEPTH) begin
                lut[w.tch][w.tidx] = w.tbyte;
                written[w.tch][w.tidx] = 1;
            end
        end else predict_pixel(w);
    endfunction

    // Channel k is read-safe if the entry it would hit was written
    function automatic bit reads_ok(word_t w);
        for (int k = 0; k < 3; k++)
            if (w.ins[k] && w.fin[k] && !written[k][lut_entry(k, w.smp[k])]) return 0;
        return 1;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LOW_RED:    win_lo[0] = val[31:0];
            REG_HIGH_RED:   win_hi[0] = val[31:0];
            REG_LOW_GREEN:  win_lo[1] = val[31:0];
            REG_HIGH_GREEN: win_hi[1] = val[31:0];
            REG_LOW_BLUE:   win_lo[2] = val[31:0];
            REG_HIGH_BLUE:  win_hi[2] = val[31:0];
            REG_TABLE_LAST: tab_last = val[11:0];
            default:        fill = val;
        endcase
    endtask

    // Wait for drain plus pipeline slack before touching registers
    task automatic wait_idle();
        while (pending_pix.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    task automatic send_word(word_t w);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 6) gap = $urandom_range(0, 40);
        else if (gap > 2) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.cmd;
        s_tdata  <= {4'd0, w.tbyte, w.tidx, w.tch, w.ins, w.fin,
                     w.smp[2], w.smp[1], w.smp[0]};
        predict_word(w);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    function automatic word_t tab_word(int ch, int ix, int b);
        word_t w;
        w = '{default: '0, smp: '{0, 0, 0}};
        w.cmd = CMD_TABLE;
        w.tch = 2'(ch); w.tidx = 12'(ix); w.tbyte = 8'(b);
        return w;
    endfunction

    // Load one table entry unless it already holds a known byte
    task automatic load_entry(int k, int ix);
        if (!written[k][ix])
            send_word(tab_word(k, ix, int'($urandom_range(0, 255))));
    endtask

    function automatic word_t pix_word(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                       logic [2:0] fm, logic [2:0] im);
        word_t w;
        w = '{default: '0, smp: '{0, 0, 0}};
        w.cmd = CMD_PIXEL;
        w.smp[0] = r; w.smp[1] = g; w.smp[2] = b;
        w.fin = fm; w.ins = im;
        w.tch = 2'($urandom); w.tidx = 12'($urandom); w.tbyte = 8'($urandom);
        return w;
    endfunction

    function automatic logic [31:0] rand_sample(int k);
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return win_lo[k] + $urandom_range(0, 3) - 1;
            3: return win_hi[k] + $urandom_range(0, 3) - 1;
            4: return $urandom;
            default: return win_lo[k] + $urandom_range(1, 1000);
        endcase
    endfunction

    // Receiver: random stalls, in-order compare
    always @(negedge aclk) begin
        int r;
        r = $urandom_range(0, 19);
        m_tready <= aresetn && (r < 14 || (r == 19 && $urandom_range(0, 1)));
    end

    always @(posedge aclk) begin
        pix_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pix.size() == 0) begin
                $display("%0t: unexpected pixel rgb=%h kind=%0d", $time, m_tdata, m_tuser);
                fails++;
            end else begin
                e = pending_pix.pop_front();
                if (m_tdata !== e.rgb) begin
                    $display("%0t: rgb mismatch exp=%h got=%h", $time, e.rgb, m_tdata);
                    fails++;
                end
                if (m_tuser !== e.kind) begin
                    $display("%0t: kind mismatch exp=%0d got=%0d", $time, e.kind, m_tuser);
                    fails++;
                end
            end
        end
    end

    // Watchdog on handshake inactivity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else if (pending_pix.size() != 0 || s_tvalid) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        row_t rows[$];
        word_t w;
        int cnt, tries;
        for (int k = 0; k < 3; k++) begin
            win_lo[k] = 0; win_hi[k] = 255;
            for (int i = 0; i < DEPTH; i++) begin
                lut[k][i] = 0; written[k][i] = 0;
            end
        end
        tab_last = 255; fill = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: reset defaults, fills, extremes
        rows.push_back('{pix_word(0, 0, 0, 3'd0, 3'd0), 1, '{24'h0, KIND_BG}});
        rows.push_back('{pix_word(0, 0, 0, 3'd0, 3'd5), 1, '{24'h0, KIND_NAN}});
        for (int k = 0; k < 3; k++) begin
            rows.push_back('{tab_word(k, 0, 8'h11 * (k + 1)), 0, '{0, 0}});
            rows.push_back('{tab_word(k, 255, 8'hf0 + k), 0, '{0, 0}});
            rows.push_back('{tab_word(k, 128, 8'h80 + k), 0, '{0, 0}});
        end
        rows.push_back('{tab_word(3, 7, 8'hff), 0, '{0, 0}});    // bad channel
        rows.push_back('{pix_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  3'd7, 3'd7), 1, '{24'h332211, KIND_GOOD}});
        rows.push_back('{pix_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                  3'd7, 3'd7), 1, '{24'hf2f1f0, KIND_GOOD}});
        rows.push_back('{pix_word(32'h7fff_ffff, 0, 0, 3'd1, 3'd3), 1,
                         '{24'h0000f0, KIND_GOOD}});        // invalid green is 0
        rows.push_back('{pix_word(128, 128, 128, 3'd7, 3'd7), 0, '{0, 0}});
        rows.push_back('{pix_word(0, 255, 1, 3'd6, 3'd2), 0, '{0, 0}});
        foreach (rows[i]) begin
            send_word(rows[i].w);
            if (rows[i].known && rows[i].w.cmd == CMD_PIXEL)
                pending_pix[$] = rows[i].res;
        end
        stop_sending();
        wait_idle();

        // Fill colors, extreme and odd windows, largest table_last
        write_reg(REG_FILL, 48'hffffff_000000);
        write_reg(REG_TABLE_LAST, 48'(12'd4095));
        write_reg(REG_LOW_RED, 48'(32'h8000_0000));
        write_reg(REG_HIGH_RED, 48'(32'h7fff_ffff));
        write_reg(REG_LOW_GREEN, 48'(32'd100));
        write_reg(REG_HIGH_GREEN, 48'(32'd100));     // empty window
        write_reg(REG_LOW_BLUE, 48'(32'd50));
        write_reg(REG_HIGH_BLUE, 48'(-32'sd50));     // inverted window
        // Entries read by the pixels below
        send_word(tab_word(0, 4095, 8'h5a));
        send_word(tab_word(1, 0, 8'ha5));
        send_word(tab_word(2, 0, 8'h3c));
        send_word(pix_word(0, 0, 0, 3'd0, 3'd0));
        send_word(pix_word(0, 0, 0, 3'd0, 3'd7));
        send_word(pix_word(32'h7fff_ffff, 100, 0, 3'd7, 3'd7));
        stop_sending();
        wait_idle();

        // Random phases across several settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_reg(REG_TABLE_LAST, 48'(12'd1));
                1: write_reg(REG_TABLE_LAST, 48'(12'd0));
                2: write_reg(REG_TABLE_LAST, 48'($urandom_range(2, 4095)));
                default: write_reg(REG_TABLE_LAST, 48'($urandom));
            endcase
            write_reg(REG_FILL, 48'({$urandom, $urandom}));
            for (int k = 0; k < 3; k++) begin
                int a, b;
                a = $urandom; b = $urandom;
                if (ph == 3) begin a = 32'h8000_0000; b = 32'h7fff_ffff; end
                else if ($urandom_range(0, 3) != 0) begin
                    a = $signed($urandom_range(0, 2000)) - 1000;
                    b = a + $urandom_range(1, 100000);
                end
                write_reg(3'(2 * k), 48'(a));
                write_reg(3'(2 * k + 1), 48'(b));
            end
            // Entries at both ends of the scale
            for (int k = 0; k < 3; k++) begin
                load_entry(k, 0);
                load_entry(k, 1);
                load_entry(k, int'(tab_last));
                if (tab_last != 0) load_entry(k, int'(tab_last) - 1);
            end
            cnt = 0;
            while (cnt < N_RANDOM / 7) begin
                if ($urandom_range(0, 9) == 0) begin
                    // occasional table rewrite, sometimes out of range channel
                    w = tab_word($urandom_range(0, 3), $urandom, $urandom);
                    send_word(w);
                end else begin
                    w = pix_word(0, 0, 0, 3'($urandom), 3'($urandom));
                    if ($urandom_range(0, 3) != 0) w.ins = 3'd7;
                    if ($urandom_range(0, 2) != 0) w.fin = w.ins;
                    for (int k = 0; k < 3; k++) begin
                        w.smp[k] = rand_sample(k);
                        // sometimes load the entry a mid-window sample lands on
                        if (w.ins[k] && w.fin[k] && $urandom_range(0, 3) == 0)
                            load_entry(k, int'(lut_entry(k, w.smp[k])));
                        tries = 0;
                        while (w.ins[k] && w.fin[k] && !written[k][lut_entry(k, w.smp[k])]
                               && tries < 20) begin
                            w.smp[k] = rand_sample(k); tries++;
                        end
                    end
                    if (reads_ok(w)) begin
                        send_word(w);
                        cnt++;
                    end
                end
                if (ph == 4 && cnt == 40) begin
                    // sender holds off until everything drains
                    stop_sending();
                    while (pending_pix.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
            end
            stop_sending();
            wait_idle();
        end

        if (fails == 0 && pending_pix.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
